FILE: sv/wsd_pkg.sv
// wsd_pkg: shared types, codes and helpers for the wraparound server dispatcher
// used by wsd_cell, wsd_ctrl, the top level and the port checker
`timescale 1ns / 1ps

package wsd_pkg;

  // default sizes handed to the top level parameters
  localparam int MAX_SERVERS_DEF = 16;
  localparam int TIME_WIDTH_DEF  = 32;

  // fixed field widths
  localparam int CNT_W  = 32;
  localparam int SRV_W  = 4;
  localparam int KIND_W = 2;
  localparam int CFG_W  = 5;

  // server count after reset
  localparam logic [CFG_W-1:0] NUM_SERVERS_RST = 5'd16;

  // input actions
  localparam logic ACT_DISPATCH = 1'b0;
  localparam logic ACT_REPORT   = 1'b1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_ASSIGN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DROP   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REPORT = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_PICK,
    S_MAX,
    S_EMIT
  } state_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic check;   // latch the free flag against the arrival time
    logic upd;     // selected cell takes the new finish time and count
    logic rotate;  // counts move one cell toward cell 0
  } cell_ctl_t;

  // saturating count increment
  function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
    cnt_inc = (c == '1) ? c : c + 1'b1;
  endfunction

endpackage

FILE: sv/wsd_cell.sv
// wsd_cell: one server slot, holding its busy-until time and request count
// depends on wsd_pkg for the control struct and the count increment
`timescale 1ns / 1ps

module wsd_cell #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  wsd_pkg::cell_ctl_t        ctl,
  input  logic                      sel,
  input  logic [TIME_WIDTH-1:0]     arr,
  input  logic [TIME_WIDTH-1:0]     fin,
  input  logic [wsd_pkg::CNT_W-1:0] cnt_in,
  output logic                      free,
  output logic [wsd_pkg::CNT_W-1:0] cnt_out
);
  import wsd_pkg::*;

  logic [TIME_WIDTH-1:0] busy_r, busy_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  free_r;

  // update on pick, otherwise pass the count along the ring
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (ctl.upd && sel) begin
      busy_nxt = fin;
      cnt_nxt  = cnt_inc(cnt_r);
    end else if (ctl.rotate) begin
      cnt_nxt = cnt_in;
    end
  end

  // slot state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // free check against the latched arrival time
  always_ff @(posedge clk) begin
    if (ctl.check) begin
      free_r <= (busy_r <= arr);
    end
  end

  assign free    = free_r;
  assign cnt_out = cnt_r;

endmodule

FILE: sv/wsd_ctrl.sv
// wsd_ctrl: sequencer, wraparound pick, report walk and result register
// depends on wsd_pkg; drives the row of wsd_cell slots
`timescale 1ns / 1ps

module wsd_ctrl #(
  parameter int MAX_SERVERS = 16,
  parameter int TIME_WIDTH  = 32
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  // input channel
  input  logic                                        in_valid,
  output logic                                        in_stall,
  input  logic                                        in_action,
  input  logic [31:0]                                 in_arrival_time,
  input  logic [31:0]                                 in_service_time,
  // result channel
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output logic [wsd_pkg::KIND_W-1:0]                  out_kind,
  output logic [wsd_pkg::SRV_W-1:0]                   out_server,
  output logic [wsd_pkg::CNT_W-1:0]                   out_handled_count,
  output logic                                        out_last,
  // configuration
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [wsd_pkg::CFG_W-1:0]                   cfg_num_servers,
  // cell row
  output wsd_pkg::cell_ctl_t                          ctl,
  output logic [MAX_SERVERS-1:0]                      sel,
  output logic [TIME_WIDTH-1:0]                       arr,
  output logic [TIME_WIDTH-1:0]                       fin,
  input  logic [MAX_SERVERS-1:0]                      free,
  input  logic [MAX_SERVERS-1:0][wsd_pkg::CNT_W-1:0]  cell_cnt
);
  import wsd_pkg::*;

  localparam int IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int KW = $clog2(MAX_SERVERS + 1);
  localparam int CW = KW + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_SERVERS - 1);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]      cfg_r;
  logic [IW-1:0]         start_r;
  logic [TIME_WIDTH-1:0] arr_r, svc_r, fin_r;
  logic [IW-1:0]         wi_r;
  logic [CNT_W-1:0]      best_r;
  logic [KW-1:0]         hits_r, emit_r;
  logic                  out_valid_r, out_last_r;
  logic [KIND_W-1:0]     out_kind_r;
  logic [SRV_W-1:0]      out_server_r;
  logic [CNT_W-1:0]      out_cnt_r;

  logic [KW-1:0]          k;
  logic [IW-1:0]          s_eff;
  logic [CW-1:0]          s_inc;
  logic [MAX_SERVERS-1:0] act, hi, cand_all, cand_hi, pick_v, pick_oh;
  logic [IW-1:0]          pick_idx;
  logic [CNT_W-1:0]       pick_cnt;
  logic                   any_free;
  logic [TIME_WIDTH:0]    sum;
  logic                   in_acc, out_free, head_in, head_hit, walk_end, step_ok;
  logic                   load_pick, load_emit;

  // servers in use, clamped to 1..MAX_SERVERS
  always_comb begin
    if (cfg_r == '0) begin
      k = KW'(1);
    end else if (32'(cfg_r) > MAX_SERVERS) begin
      k = KW'(MAX_SERVERS);
    end else begin
      k = KW'(cfg_r);
    end
  end

  // search start and the next sequence position
  assign s_eff = (KW'(start_r) < k) ? start_r : '0;
  assign s_inc = CW'(s_eff) + 1'b1;

  // wraparound priority pick over the free flags
  always_comb begin
    for (int i = 0; i < MAX_SERVERS; i++) begin
      act[i] = (KW'(i) < k);
      hi[i]  = (IW'(i) >= s_eff);
    end
    cand_all = free & act;
    cand_hi  = cand_all & hi;
    any_free = |cand_all;
    pick_v   = (|cand_hi) ? cand_hi : cand_all;
    pick_oh  = pick_v & (~pick_v + 1'b1);
    pick_idx = '0;
    pick_cnt = '0;
    for (int i = 0; i < MAX_SERVERS; i++) begin
      pick_idx = pick_idx | (pick_oh[i] ? IW'(i) : '0);
      pick_cnt = pick_cnt | (pick_oh[i] ? cell_cnt[i] : '0);
    end
  end

  // saturating finish time
  assign sum = {1'b0, arr_r} + {1'b0, svc_r};

  // handshake and walk status
  assign out_free = !out_valid_r || !out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign head_in  = (KW'(wi_r) < k);
  assign head_hit = head_in && (cell_cnt[0] == best_r);
  assign walk_end = (wi_r == LAST_IDX);
  assign step_ok  = !head_hit || out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_action == ACT_REPORT) ? S_MAX : S_CHECK;
        end
      end
      S_CHECK: state_nxt = S_PICK;
      S_PICK: begin
        if (out_free) begin
          if (in_acc) begin
            state_nxt = (in_action == ACT_REPORT) ? S_MAX : S_CHECK;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_MAX: begin
        if (walk_end) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (step_ok && walk_end) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall   = 1'b1;
    ctl.check  = 1'b0;
    ctl.upd    = 1'b0;
    ctl.rotate = 1'b0;
    load_pick  = 1'b0;
    load_emit  = 1'b0;
    unique case (state_r)
      S_IDLE:  in_stall = 1'b0;
      S_CHECK: ctl.check = 1'b1;
      S_PICK: begin
        in_stall  = !out_free;
        load_pick = out_free;
        ctl.upd   = out_free && any_free;
      end
      S_MAX: ctl.rotate = 1'b1;
      S_EMIT: begin
        ctl.rotate = step_ok;
        load_emit  = head_hit && out_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= NUM_SERVERS_RST;
      start_r     <= '0;
      out_valid_r <= 1'b0;
      wi_r        <= '0;
      best_r      <= '0;
      hits_r      <= '0;
      emit_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        cfg_r <= cfg_num_servers;
      end
      // sequence position moves on every dispatch
      if (load_pick) begin
        start_r <= (s_inc >= CW'(k)) ? '0 : IW'(s_inc);
      end
      // result register
      if (load_pick || load_emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      // report walk
      if (in_acc) begin
        wi_r   <= '0;
        best_r <= '0;
        hits_r <= '0;
        emit_r <= '0;
      end else if (state_r == S_MAX) begin
        wi_r <= walk_end ? '0 : wi_r + 1'b1;
        if (head_in) begin
          if (cell_cnt[0] > best_r) begin
            best_r <= cell_cnt[0];
            hits_r <= KW'(1);
          end else if (cell_cnt[0] == best_r) begin
            hits_r <= hits_r + 1'b1;
          end
        end
      end else if (state_r == S_EMIT && step_ok) begin
        wi_r <= wi_r + 1'b1;
        if (load_emit) begin
          emit_r <= emit_r + 1'b1;
        end
      end
    end
  end

  // item latches and finish time
  always_ff @(posedge clk) begin
    if (in_acc) begin
      arr_r <= TIME_WIDTH'(in_arrival_time);
      svc_r <= TIME_WIDTH'(in_service_time);
    end
    if (state_r == S_CHECK) begin
      fin_r <= sum[TIME_WIDTH] ? '1 : sum[TIME_WIDTH-1:0];
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load_pick) begin
      out_kind_r   <= any_free ? KIND_ASSIGN : KIND_DROP;
      out_server_r <= any_free ? SRV_W'(pick_idx) : '0;
      out_cnt_r    <= any_free ? cnt_inc(pick_cnt) : '0;
      out_last_r   <= 1'b1;
    end else if (load_emit) begin
      out_kind_r   <= KIND_REPORT;
      out_server_r <= SRV_W'(wi_r);
      out_cnt_r    <= best_r;
      out_last_r   <= (emit_r + 1'b1 == hits_r);
    end
  end

  assign sel               = pick_oh;
  assign arr               = arr_r;
  assign fin               = fin_r;
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_server        = out_server_r;
  assign out_handled_count = out_cnt_r;
  assign out_last          = out_last_r;

endmodule

FILE: sv/wraparound_server_dispatcher_top.sv
// wraparound_server_dispatcher_top: row of server cells plus the sequencer
// depends on wsd_pkg, wsd_cell and wsd_ctrl
`timescale 1ns / 1ps
//
// Usage
// - input channel (in_valid / in_stall): one item is a dispatch (in_action 0)
//   or a report (in_action 1), with arrival and service times
// - result channel (out_valid / out_stall): a dispatch gives one item, assigned
//   or dropped, with out_last set; a report gives one item per busiest server
//   in index order, out_last on the final one
// - cfg_num_servers sets how many servers are in use; write it only while idle
// - a dispatch has a check step, where the cells compare their busy times, then
//   a pick step with the wraparound pick and the slot update; the result is
//   registered as the pick step ends and the next item can be taken on that edge
// - a report rotates the counts around the cell ring twice, once to find the
//   maximum and hit count, once to emit
// - a stalled result holds its payload; while the result register is full and
//   stalled, a dispatch waits in its pick step and a report waits at a busiest server
// - reset clears every busy time and count at once, the sequence position to 0
//   and the server count to 16; the block takes items on the next cycle
//
module wraparound_server_dispatcher_top #(
  parameter int MAX_SERVERS = wsd_pkg::MAX_SERVERS_DEF,
  parameter int TIME_WIDTH  = wsd_pkg::TIME_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_action,
  input  logic [31:0]                 in_arrival_time,
  input  logic [31:0]                 in_service_time,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [wsd_pkg::KIND_W-1:0]  out_kind,
  output logic [wsd_pkg::SRV_W-1:0]   out_server,
  output logic [wsd_pkg::CNT_W-1:0]   out_handled_count,
  output logic                        out_last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [wsd_pkg::CFG_W-1:0]   cfg_num_servers
);
  import wsd_pkg::*;

  cell_ctl_t                         ctl;
  logic [MAX_SERVERS-1:0]            sel;
  logic [MAX_SERVERS-1:0]            free;
  logic [TIME_WIDTH-1:0]             arr, fin;
  logic [MAX_SERVERS-1:0][CNT_W-1:0] cell_cnt;

  // sequencer
  wsd_ctrl #(
    .MAX_SERVERS (MAX_SERVERS),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_arrival_time   (in_arrival_time),
    .in_service_time   (in_service_time),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_server        (out_server),
    .out_handled_count (out_handled_count),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_num_servers   (cfg_num_servers),
    .ctl               (ctl),
    .sel               (sel),
    .arr               (arr),
    .fin               (fin),
    .free              (free),
    .cell_cnt          (cell_cnt)
  );

  // ring of server cells, counts flow toward cell 0
  for (genvar i = 0; i < MAX_SERVERS; i++) begin : g_cell
    wsd_cell #(
      .TIME_WIDTH (TIME_WIDTH)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .sel     (sel[i]),
      .arr     (arr),
      .fin     (fin),
      .cnt_in  (cell_cnt[(i + 1) % MAX_SERVERS]),
      .free    (free[i]),
      .cnt_out (cell_cnt[i])
    );
  end

endmodule

FILE: sv/wsd_checker.sv
// wsd_checker: port-level checks on the dispatcher result channel
// depends on wsd_pkg; bound to wraparound_server_dispatcher_top below
`timescale 1ns / 1ps

module wsd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [wsd_pkg::KIND_W-1:0] out_kind,
  input logic [wsd_pkg::SRV_W-1:0]  out_server,
  input logic [wsd_pkg::CNT_W-1:0]  out_handled_count,
  input logic                       out_last
);
  import wsd_pkg::*;

  // a dropped item carries no server and no count
  a_drop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DROP |-> out_server == '0 && out_handled_count == '0)
    else $error("dropped item carries a server or count");

  // every dispatch item (assign or drop) carries out_last
  a_dispatch_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_REPORT |-> out_last)
    else $error("dispatch item without last");

  // an assigned server has taken at least this request
  a_assign_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ASSIGN |-> out_handled_count != '0)
    else $error("assigned item with zero count");

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_server)
      && $stable(out_handled_count) && $stable(out_last))
    else $error("stalled result item changed");

endmodule

bind wraparound_server_dispatcher_top wsd_checker u_wsd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_kind          (out_kind),
  .out_server        (out_server),
  .out_handled_count (out_handled_count),
  .out_last          (out_last)
);
